// ----- rtl/dlcg_pkg.sv -----
package dlcg_pkg;

	localparam int COORD_INT_BITS_DEF  = 12;
	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int STEP_FRAC_BITS_DEF  = 24;
	localparam int OUT_W               = 12;
	localparam int COLOR_W             = 24;
	localparam int CH_W                = 8;
	localparam int NUM_CH              = 3;

	typedef enum logic [0:0] {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_RUN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch endpoints, colors, start divisions
		logic div_step;  // advance the dividers one bit
		logic emit;      // capture one pixel into the output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic span_zero;
		logic div_done;
		logic done;      // the pixel being emitted ends the line
	} dp_stat_t;

endpackage

// ----- rtl/dlcg_datapath.sv -----
module dlcg_datapath #(
	parameter int COORD_INT_BITS  = dlcg_pkg::COORD_INT_BITS_DEF,
	parameter int COORD_FRAC_BITS = dlcg_pkg::COORD_FRAC_BITS_DEF,
	parameter int STEP_FRAC_BITS  = dlcg_pkg::STEP_FRAC_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  dlcg_pkg::dp_cmd_t                            cmd,
	output dlcg_pkg::dp_stat_t                           stat,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_x,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_y,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_x,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_y,
	input  logic [dlcg_pkg::COLOR_W-1:0]                 start_color,
	input  logic [dlcg_pkg::COLOR_W-1:0]                 finish_color,
	output logic signed [dlcg_pkg::OUT_W-1:0]            px_x,
	output logic signed [dlcg_pkg::OUT_W-1:0]            px_y,
	output logic [dlcg_pkg::COLOR_W-1:0]                 px_color
);
	import dlcg_pkg::*;

	localparam int CW    = COORD_INT_BITS + COORD_FRAC_BITS;
	localparam int SH    = STEP_FRAC_BITS - COORD_FRAC_BITS;
	localparam int MW    = CW + 1;              // delta magnitude
	localparam int SPW   = MW - COORD_FRAC_BITS; // span
	localparam int QW    = MW + SH;             // step magnitude / dividend
	localparam int AW    = QW + 2;              // accumulator
	localparam int CNTW  = $clog2(QW + 1);
	localparam int PXW   = AW - STEP_FRAC_BITS;
	localparam int CDW   = CH_W + 1;            // color increment dividend
	localparam int CSTOP = QW - CDW;            // color dividers run while dcnt_q is above this

	// line state
	logic signed [AW-1:0]  pos_x_q, pos_y_q, tgt_x_q, tgt_y_q, stp_x_q, stp_y_q;
	logic [SPW-1:0]        span_q, cnt_q;
	logic [COLOR_W-1:0]    end_col_q, cur_col_q;
	logic                  neg_x_q, neg_y_q, col_done_q;

	// color gradient by remainder: value = floor(base + diff*n/span), from floor(|diff|*n/span) tracked incrementally
	logic [CH_W-1:0]       cbase_q [NUM_CH];
	logic                  cneg_q  [NUM_CH];
	logic [CH_W-1:0]       cq_q    [NUM_CH];   // floor(|diff|*n/span)
	logic [SPW-1:0]        cr_q    [NUM_CH];   // remainder
	// per-pixel increment |diff|/span: quotient shifts into cdv_q, remainder in crm_q
	logic [CDW-1:0]        cdv_q   [NUM_CH];
	logic [SPW-1:0]        crm_q   [NUM_CH];

	// restoring dividers for the two steps
	logic [QW-1:0]         dvx_q, dvy_q;
	logic [SPW:0]          rmx_q, rmy_q;
	logic [CNTW-1:0]       dcnt_q;

	logic signed [CW:0]    dx, dy;
	logic [MW-1:0]         mx, my, big;

	always_comb begin
		dx  = (CW+1)'(end_x) - (CW+1)'(start_x);
		dy  = (CW+1)'(end_y) - (CW+1)'(start_y);
		mx  = dx[CW] ? MW'(-dx) : MW'(dx);
		my  = dy[CW] ? MW'(-dy) : MW'(dy);
		big = (mx > my) ? mx : my;
	end

	function automatic logic signed [AW-1:0] widen(input logic signed [CW-1:0] v);
		widen = AW'(v) <<< SH;
	endfunction

	function automatic logic signed [PXW-1:0] trunc_px(input logic signed [AW-1:0] p);
		logic [AW-1:0] m;
		m = p[AW-1] ? AW'(-p) : AW'(p);
		m = m >> STEP_FRAC_BITS;
		trunc_px = p[AW-1] ? PXW'(-m) : PXW'(m);
	endfunction

	logic [SPW:0]   trx, try_;
	logic signed [AW-1:0] nx, ny;
	logic [SPW-1:0] ncnt;

	always_comb begin
		trx  = {rmx_q[SPW-1:0], dvx_q[QW-1]};
		try_ = {rmy_q[SPW-1:0], dvy_q[QW-1]};
		nx   = pos_x_q + stp_x_q;
		ny   = pos_y_q + stp_y_q;
		ncnt = cnt_q + 1'b1;
	end

	// incremental color: add the precomputed increment, carry one when the remainder wraps
	logic [CH_W-1:0] iq [NUM_CH];
	logic [SPW-1:0]  ir [NUM_CH];
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			logic [SPW:0] rs;
			rs = (SPW+1)'(cr_q[c]) + (SPW+1)'(crm_q[c]);
			if (rs >= (SPW+1)'(span_q)) begin
				iq[c] = cq_q[c] + cdv_q[c][CH_W-1:0] + CH_W'(1);
				ir[c] = SPW'(rs - (SPW+1)'(span_q));
			end else begin
				iq[c] = cq_q[c] + cdv_q[c][CH_W-1:0];
				ir[c] = SPW'(rs);
			end
		end
	end

	logic [COLOR_W-1:0] blend_col;
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			logic [CH_W-1:0] v;
			logic [CH_W:0]   t;
			// floor for negative diff: base - ceil(|d|n/s)
			t = cneg_q[c] ? ((CH_W+1)'(cbase_q[c]) - (CH_W+1)'(iq[c])
			                 - ((ir[c] != '0) ? (CH_W+1)'(1) : '0))
			              : ((CH_W+1)'(cbase_q[c]) + (CH_W+1)'(iq[c]));
			v = t[CH_W-1:0];
			blend_col[(NUM_CH-1-c)*CH_W +: CH_W] = v;
		end
	end

	logic near_x, near_y;
	always_comb begin
		near_x = (trunc_px(nx - tgt_x_q) == '0);
		near_y = (trunc_px(ny - tgt_y_q) == '0);
		stat.done      = (near_x && near_y) || (ncnt >= span_q);
		stat.span_zero = (big[MW-1:COORD_FRAC_BITS] == '0);
		stat.div_done  = (dcnt_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= CNTW'(QW);
		end else if (cmd.div_step && dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			span_q    <= big[MW-1:COORD_FRAC_BITS];
			cnt_q     <= '0;
			pos_x_q   <= widen(start_x);
			pos_y_q   <= widen(start_y);
			tgt_x_q   <= widen(end_x);
			tgt_y_q   <= widen(end_y);
			neg_x_q   <= dx[CW];
			neg_y_q   <= dy[CW];
			dvx_q     <= QW'(mx) << SH;
			dvy_q     <= QW'(my) << SH;
			rmx_q     <= '0;
			rmy_q     <= '0;
			end_col_q <= finish_color;
			cur_col_q <= start_color;
			col_done_q <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				logic [CH_W-1:0] a, e;
				a = start_color[(NUM_CH-1-c)*CH_W +: CH_W];
				e = finish_color[(NUM_CH-1-c)*CH_W +: CH_W];
				cbase_q[c] <= a;
				cneg_q[c]  <= (e < a);
				cdv_q[c]   <= (e < a) ? CDW'(a - e) : CDW'(e - a);
				crm_q[c]   <= '0;
				cq_q[c]    <= '0;
				cr_q[c]    <= '0;
			end
		end else if (cmd.div_step && dcnt_q != '0) begin
			if (trx >= (SPW+1)'(span_q)) begin
				rmx_q <= trx - (SPW+1)'(span_q);
				dvx_q <= {dvx_q[QW-2:0], 1'b1};
			end else begin
				rmx_q <= trx;
				dvx_q <= {dvx_q[QW-2:0], 1'b0};
			end
			if (try_ >= (SPW+1)'(span_q)) begin
				rmy_q <= try_ - (SPW+1)'(span_q);
				dvy_q <= {dvy_q[QW-2:0], 1'b1};
			end else begin
				rmy_q <= try_;
				dvy_q <= {dvy_q[QW-2:0], 1'b0};
			end
			// color increments need only the first CDW quotient bits
			if (dcnt_q > CNTW'(CSTOP)) begin
				for (int c = 0; c < NUM_CH; c++) begin
					logic [SPW:0] ct;
					ct = {crm_q[c], cdv_q[c][CH_W]};
					if (ct >= (SPW+1)'(span_q)) begin
						crm_q[c] <= SPW'(ct - (SPW+1)'(span_q));
						cdv_q[c] <= {cdv_q[c][CH_W-1:0], 1'b1};
					end else begin
						crm_q[c] <= SPW'(ct);
						cdv_q[c] <= {cdv_q[c][CH_W-1:0], 1'b0};
					end
				end
			end
		end else if (cmd.emit) begin
			px_x     <= OUT_W'(trunc_px(pos_x_q));
			px_y     <= OUT_W'(trunc_px(pos_y_q));
			px_color <= cur_col_q;
			cnt_q    <= ncnt;
			pos_x_q  <= nx;
			pos_y_q  <= ny;
			for (int c = 0; c < NUM_CH; c++) begin
				cq_q[c] <= iq[c];
				cr_q[c] <= ir[c];
			end
			if (!col_done_q && cur_col_q != end_col_q) begin
				cur_col_q <= blend_col;
			end else begin
				col_done_q <= 1'b1;
			end
		end
	end

	// signed steps, formed once the dividers finish
	logic signed [AW-1:0] sx_w, sy_w;
	always_comb begin
		sx_w = neg_x_q ? -AW'(dvx_q) : AW'(dvx_q);
		sy_w = neg_y_q ? -AW'(dvy_q) : AW'(dvy_q);
	end
	always_ff @(posedge clk) begin
		if (stat.div_done && !cmd.emit) begin
			stp_x_q <= sx_w;
			stp_y_q <= sy_w;
		end
	end

endmodule

// ----- rtl/dlcg_ctrl.sv -----
module dlcg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dlcg_pkg::cmd_t      in_cmd,
	input  dlcg_pkg::dp_stat_t  stat,
	output dlcg_pkg::dp_cmd_t   cmd,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                out_last
);
	import dlcg_pkg::*;

	state_t state_q, state_d;
	logic   acc, ov_q, last_q, out_free;

	assign out_free = !ov_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		in_stall     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE, ST_RUN: begin
				// hold a step in ST_RUN while the output register holds a stalled pixel
				in_stall = (in_cmd == CMD_STEP) && (state_q == ST_RUN) && !out_free;
			end
			ST_DIV: begin
				in_stall     = 1'b1;
				cmd.div_step = 1'b1;
				if (stat.div_done)
					state_d = ST_RUN;
			end
			default: state_d = ST_IDLE;
		endcase
		acc = in_valid && !in_stall;
		if (acc && in_cmd == CMD_LOAD) begin
			cmd.load = 1'b1;
			state_d  = stat.span_zero ? ST_IDLE : ST_DIV;
		end else if (acc && in_cmd == CMD_STEP && state_q == ST_RUN) begin
			cmd.emit = 1'b1;
			if (stat.done)
				state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				ov_q   <= 1'b1;
				last_q <= stat.done;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_last  = last_q;

endmodule

// ----- rtl/dda_line_color_gradient.sv -----
// DDA line rasterizer with RGB gradient.
// Input channel (in_valid/in_stall): command 0 loads a line from two signed
// fixed-point endpoints and two colors; command 1 asks for the next pixel.
// Output channel (out_valid/out_stall): one transfer per pixel with its
// position truncated toward zero, its color and a last_pixel flag.
// A load is taken in the cycle of its transfer; the input then stalls while
// restoring dividers form the x and y steps and the per-channel color
// increments, one quotient bit per cycle. A zero-length line takes no
// division and emits nothing. Steps then run one per cycle unless the
// output stalls; a pixel appears in the cycle after its step command is
// taken. The output register holds a pixel while out_stall is high and
// step commands stall meanwhile; loads are still taken, dropping the line
// in progress. Steps with no active line are taken and dropped.
// Reset clears the controller and the output valid flag.
module dda_line_color_gradient #(
	parameter int COORD_INT_BITS  = dlcg_pkg::COORD_INT_BITS_DEF,
	parameter int COORD_FRAC_BITS = dlcg_pkg::COORD_FRAC_BITS_DEF,
	parameter int STEP_FRAC_BITS  = dlcg_pkg::STEP_FRAC_BITS_DEF
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              in_valid,
	output logic                                              in_stall,
	input  logic                                              command,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  start_x,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  start_y,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  end_x,
	input  logic signed [COORD_INT_BITS+COORD_FRAC_BITS-1:0]  end_y,
	input  logic [dlcg_pkg::COLOR_W-1:0]                      start_color,
	input  logic [dlcg_pkg::COLOR_W-1:0]                      finish_color,
	output logic                                              out_valid,
	input  logic                                              out_stall,
	output logic signed [dlcg_pkg::OUT_W-1:0]                 pixel_x,
	output logic signed [dlcg_pkg::OUT_W-1:0]                 pixel_y,
	output logic [dlcg_pkg::COLOR_W-1:0]                      pixel_color,
	output logic                                              last_pixel
);
	import dlcg_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t dstat;

	dlcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_cmd    (cmd_t'(command)),
		.stat      (dstat),
		.cmd       (dcmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_last  (last_pixel)
	);

	dlcg_datapath #(
		.COORD_INT_BITS  (COORD_INT_BITS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.STEP_FRAC_BITS  (STEP_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dcmd),
		.stat         (dstat),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.start_color  (start_color),
		.finish_color (finish_color),
		.px_x         (pixel_x),
		.px_y         (pixel_y),
		.px_color     (pixel_color)
	);

endmodule

// ----- rtl/dlcg_checker.sv -----
module dlcg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic command,
	input logic out_valid,
	input logic out_stall,
	input logic last_pixel
);
	// a stalled pixel keeps its last flag
	a_last_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(last_pixel))
		else $error("stalled last flag changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled pixel dropped");

	a_no_pixel_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !command && !(out_valid && out_stall) |=> !out_valid)
		else $error("pixel after load");

endmodule

bind dda_line_color_gradient dlcg_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.command    (command),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.last_pixel (last_pixel)
);

// ----- verif/dda_line_color_gradient_tb.sv -----
`timescale 1ns / 1ps

module dda_line_color_gradient_tb;
	import dlcg_pkg::*;

	localparam int CW          = COORD_INT_BITS_DEF + COORD_FRAC_BITS_DEF;
	localparam int FRAC_SHIFT  = STEP_FRAC_BITS_DEF - COORD_FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic signed [CW-1:0] coord_t;

	// One emitted pixel as the block should present it
	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [COLOR_W-1:0]      color;
		logic                    last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = CMD_LOAD;
	coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [COLOR_W-1:0] start_color = '0, finish_color = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] pixel_x, pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic last_pixel;

	dda_line_color_gradient u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.start_color(start_color), .finish_color(finish_color),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_color(pixel_color), .last_pixel(last_pixel)
	);

	// Rasterizer state as the predictor tracks it
	bit      line_on;
	longint  pos_x, pos_y, inc_x, inc_y, goal_x, goal_y;
	longint  line_span, emitted;
	logic [COLOR_W-1:0] color_from, color_to, color_now;

	pixel_t  pending_pixels[$];
	int      errors;
	int      loads_sent, steps_sent, pixels_checked;
	int      gap_pct, stall_pct;
	int      hold_req;
	int      cycles;

	// Clock: 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels pending", cycles,
				pending_pixels.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, or a long hold-off when a test asks for one
	always @(posedge clk) begin
		if (hold_req > 0) begin
			out_stall <= 1'b1;
			hold_req--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Drop the fraction, rounding toward zero
	function automatic longint trunc_pixel(longint p);
		longint m;
		m = mag(p) >> STEP_FRAC_BITS_DEF;
		return p < 0 ? -m : m;
	endfunction

	// Linear blend of one 8-bit channel after n of s pixels
	function automatic longint mix_channel(longint a, longint b, longint n, longint s);
		if (s == 0)
			return a;
		if (n > s)
			n = s;
		return (a * (s - n) + b * n) / s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// Update the predicted state for one accepted transfer; queue the pixel it makes
	task automatic predict_transfer(cmd_t cmd, coord_t sx, coord_t sy, coord_t ex,
			coord_t ey, logic [COLOR_W-1:0] c0, logic [COLOR_W-1:0] c1);
		longint dx, dy, mx, my, big, q;
		logic [CH_W-1:0] r, g, b;
		pixel_t px;
		if (cmd == CMD_LOAD) begin
			dx = longint'(ex) - longint'(sx);
			dy = longint'(ey) - longint'(sy);
			mx = mag(dx);
			my = mag(dy);
			big = mx > my ? mx : my;
			line_span = big >> COORD_FRAC_BITS_DEF;
			emitted = 0;
			color_from = c0;
			color_to = c1;
			color_now = c0;
			pos_x = longint'(sx) * (64'sd1 << FRAC_SHIFT);
			pos_y = longint'(sy) * (64'sd1 << FRAC_SHIFT);
			goal_x = longint'(ex) * (64'sd1 << FRAC_SHIFT);
			goal_y = longint'(ey) * (64'sd1 << FRAC_SHIFT);
			if (line_span == 0) begin
				inc_x = 0;
				inc_y = 0;
				line_on = 0;
			end else begin
				q = (mx << FRAC_SHIFT) / line_span;
				inc_x = dx < 0 ? -q : q;
				q = (my << FRAC_SHIFT) / line_span;
				inc_y = dy < 0 ? -q : q;
				line_on = 1;
			end
			return;
		end
		// Step with no line: dropped
		if (!line_on)
			return;
		px.x = OUT_W'(trunc_pixel(pos_x));
		px.y = OUT_W'(trunc_pixel(pos_y));
		px.color = color_now;
		emitted++;
		pos_x += inc_x;
		pos_y += inc_y;
		// Hold the color once it has reached the end color
		if (color_now != color_to) begin
			r = CH_W'(mix_channel(color_from[23:16], color_to[23:16], emitted, line_span));
			g = CH_W'(mix_channel(color_from[15:8], color_to[15:8], emitted, line_span));
			b = CH_W'(mix_channel(color_from[7:0], color_to[7:0], emitted, line_span));
			color_now = {r, g, b};
		end
		px.last = (trunc_pixel(pos_x - goal_x) == 0 && trunc_pixel(pos_y - goal_y) == 0)
			|| emitted >= line_span;
		if (px.last)
			line_on = 0;
		pending_pixels.push_back(px);
	endtask

	// Offer one item, hold it until the block takes it, then predict
	task automatic send_item(cmd_t cmd, coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			logic [COLOR_W-1:0] c0, logic [COLOR_W-1:0] c1);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		start_color <= c0;
		finish_color <= c1;
		do
			@(posedge clk);
		while (in_stall);
		if (cmd == CMD_LOAD)
			loads_sent++;
		else
			steps_sent++;
		predict_transfer(cmd, sx, sy, ex, ey, c0, c1);
	endtask

	// Step with random filler on the unused fields
	task automatic send_step();
		send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
	endtask

	// Drop valid and wait until every predicted pixel has come out
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Checker: compare each output transfer with the oldest prediction
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("pixel with none expected, pixel_x", pixel_x, 0);
			end else begin
				want = pending_pixels.pop_front();
				pixels_checked++;
				if (pixel_x !== want.x)
					report_mismatch("pixel_x", pixel_x, want.x);
				if (pixel_y !== want.y)
					report_mismatch("pixel_y", pixel_y, want.y);
				if (pixel_color !== want.color)
					report_mismatch("pixel_color", pixel_color, want.color);
				if (last_pixel !== want.last)
					report_mismatch("last_pixel", last_pixel, want.last);
			end
		end
	end

	// Load a short random line and step it through, sometimes cut short
	task automatic random_line(int max_px);
		int sx, sy, dx, dy, ex, ey, n;
		logic [COLOR_W-1:0] c0, c1;
		sx = int'(coord_t'($urandom));
		sy = int'(coord_t'($urandom));
		dx = $urandom_range(max_px * 256);
		dy = $urandom_range(max_px * 256);
		if ($urandom_range(1)) dx = -dx;
		if ($urandom_range(1)) dy = -dy;
		// Fold the end back inside the coordinate range
		ex = (sx + dx > 524287 || sx + dx < -524288) ? sx - dx : sx + dx;
		ey = (sy + dy > 524287 || sy + dy < -524288) ? sy - dy : sy + dy;
		c0 = COLOR_W'($urandom);
		c1 = $urandom_range(7) == 0 ? c0 : COLOR_W'($urandom);
		send_item(CMD_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey), c0, c1);
		n = int'(line_span) + $urandom_range(1);
		if ($urandom_range(9) == 0)
			n = $urandom_range(n);
		repeat (n)
			send_step();
	endtask

	// Mostly well-formed lines, some noise: stray steps and full-range loads
	task automatic random_phase(int items);
		int start;
		start = loads_sent + steps_sent;
		while (loads_sent + steps_sent - start < items) begin
			case ($urandom_range(9))
				0: send_step();
				1: begin
					send_item(CMD_LOAD, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), coord_t'($urandom),
						COLOR_W'($urandom), COLOR_W'($urandom));
					repeat ($urandom_range(4))
						send_step();
				end
				default: random_line($urandom_range(3) == 0 ? 40 : 12);
			endcase
		end
		wait_drain();
	endtask

	task automatic test_directed();
		gap_pct = 0;
		stall_pct = 0;
		// Step with no line loaded
		send_step();
		// Zero-span load: sub-pixel delta gives no pixels
		send_item(CMD_LOAD, 20'sd100, 20'sd100, 20'sd355, 20'sd200, 24'h123456, 24'h654321);
		send_step();
		// Short line that reaches its target, black to white
		send_item(CMD_LOAD, 20'sd0, 20'sd0, 20'sd1024, 20'sd512, 24'h000000, 24'hFFFFFF);
		repeat (5)
			send_step();
		// Negative coordinates truncate toward zero, white to black
		send_item(CMD_LOAD, -20'sd300, -20'sd50, -20'sd1100, 20'sd700, 24'hFFFFFF, 24'h000000);
		repeat (4)
			send_step();
		// Extreme corners; drop the line in progress with a new load
		send_item(CMD_LOAD, -20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287,
			24'hFF00FF, 24'h00FF00);
		repeat (3)
			send_step();
		send_item(CMD_LOAD, 20'sd524287, -20'sd524288, -20'sd524288, 20'sd524287,
			24'h00FF00, 24'hFF00FF);
		repeat (2)
			send_step();
		// Equal colors stay put
		send_item(CMD_LOAD, 20'sd768, 20'sd0, 20'sd0, 20'sd0, 24'hABCDEF, 24'hABCDEF);
		repeat (4)
			send_step();
		wait_drain();
	endtask

	task automatic test_no_idle();
		gap_pct = 0;
		stall_pct = 0;
		random_phase(80);
	endtask

	task automatic test_sender_idle();
		gap_pct = 86;
		stall_pct = 0;
		random_phase(80);
	endtask

	task automatic test_receiver_stall();
		gap_pct = 0;
		stall_pct = 86;
		random_phase(80);
	endtask

	task automatic test_both_idle();
		gap_pct = 16;
		stall_pct = 16;
		random_phase(80);
	endtask

	// Hold the output for a long stretch while steps keep coming, so the block backs up
	task automatic test_backpressure();
		gap_pct = 0;
		stall_pct = 0;
		send_item(CMD_LOAD, 20'sd0, 20'sd0, 20'sd7680, -20'sd2560, 24'h102030, 24'hF0E0D0);
		hold_req = 200;
		repeat (31)
			send_step();
		wait_drain();
		// Pause until everything is out, then go on
		random_line(12);
		wait_drain();
		random_phase(50);
	endtask

	initial begin
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_backpressure();
		repeat (100)
			@(posedge clk);
		$display("covered %0d loads and %0d steps, %0d pixels checked,", loads_sent,
			steps_sent, pixels_checked);
		$display("under free flow, sender gaps, receiver stalls and a long hold-off");
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d errors, %0d pixels never arrived", errors, pending_pixels.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/dlcg_pkg.sv
rtl/dlcg_datapath.sv
rtl/dlcg_ctrl.sv
rtl/dda_line_color_gradient.sv
rtl/dlcg_checker.sv
verif/dda_line_color_gradient_tb.sv
